FILE: rtl/windowed_watchdog_timer_defines.svh
// Assertion helpers used by the watchdog top-level RTL.
`ifndef WINDOWED_WATCHDOG_TIMER_DEFINES_SVH
`define WINDOWED_WATCHDOG_TIMER_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define WWDT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog check failed");

// Next-cycle implication, checked on every rising clk outside reset.
`define WWDT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog check failed");

`endif

FILE: rtl/wwdt_pkg.sv
package wwdt_pkg;

  localparam int CLK_W        = 27;
  localparam int LEN_W        = 32;
  localparam int CODE_W       = 4;
  localparam int OP_W         = 3;
  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int MAX_CODE_DEF = 11;

  localparam logic [CLK_W-1:0]  CLOCK_HZ_RST = CLK_W'(16000000);
  localparam logic [ADDR_W-1:0] ADDR_CLOCK_HZ = ADDR_W'(0);

  localparam logic [OP_W-1:0] OP_TICK     = OP_W'(0);
  localparam logic [OP_W-1:0] OP_WDR      = OP_W'(1);
  localparam logic [OP_W-1:0] OP_WR_CTRL  = OP_W'(2);
  localparam logic [OP_W-1:0] OP_WR_STAT  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_RD_STAT  = OP_W'(4);

  localparam logic [BYTE_W-1:0] LOCK_MASK = BYTE_W'(8'h80);

  // One registered input beat, with both period lengths already decoded.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] wdata;
    logic              ccp_open;
    logic [LEN_W-1:0]  timeout_len;
    logic [LEN_W-1:0]  window_len;
  } item_t;

endpackage

FILE: rtl/windowed_watchdog_timer.sv
// Windowed watchdog timer, reset only. Unless stalled, one beat enters per
// clock: a tick, a watchdog restart (WDR), a control-byte write, a status
// write or a status read; each beat yields exactly one result beat (rdata,
// device_reset). The control byte low nibble picks the timeout, the high
// nibble the closed window: code c in 1..MAX_CODE means (8 << (c-1)) *
// clock_hz / 1024 ticks (at least 1), any other code means off. device_reset
// is 1 on the result of the tick that reaches the timeout, or of a WDR that
// lands inside the closed window; that event also clears the control byte,
// the lock and the count. Each beat passes an input register (where the
// period nibbles are decoded to tick counts) and a result register, with
// the state update done between them; a new beat can enter while the one
// before it moves on. clock_hz sits at APB byte address 0 and should only
// be written while the block is idle.
`include "windowed_watchdog_timer_defines.svh"

module windowed_watchdog_timer #(
  parameter int MAX_CODE = wwdt_pkg::MAX_CODE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wwdt_pkg::ADDR_W-1:0] paddr,
  input  logic [wwdt_pkg::DATA_W-1:0] pwdata,
  output logic [wwdt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // input beat channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wwdt_pkg::OP_W-1:0]   op,
  input  logic [wwdt_pkg::BYTE_W-1:0] wdata,
  input  logic                        ccp_open,
  // result beat channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wwdt_pkg::BYTE_W-1:0] rdata,
  output logic                        device_reset
);

  logic [wwdt_pkg::CLK_W-1:0] clock_hz;
  logic                       cfg_wr;

  wwdt_pkg::item_t            item_q;
  logic                       item_vld;
  logic                       take;
  logic                       in_accept;
  logic [wwdt_pkg::LEN_W-1:0] timeout_dec;
  logic [wwdt_pkg::LEN_W-1:0] window_dec;

  // Config register: a single word, fully decoded so stray addresses drop.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == wwdt_pkg::ADDR_CLOCK_HZ);
  assign prdata = (paddr == wwdt_pkg::ADDR_CLOCK_HZ) ?
                  wwdt_pkg::DATA_W'(clock_hz) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= wwdt_pkg::CLOCK_HZ_RST;
    end else if (cfg_wr) begin
      clock_hz <= pwdata[wwdt_pkg::CLK_W-1:0];
    end
  end

  // Decode both nibbles on the way in so the state update only compares.
  wwdt_len_dec #(.MAX_CODE(MAX_CODE)) u_dec_timeout (
    .code     (wdata[3:0]),
    .clock_hz (clock_hz),
    .len      (timeout_dec)
  );

  wwdt_len_dec #(.MAX_CODE(MAX_CODE)) u_dec_window (
    .code     (wdata[7:4]),
    .clock_hz (clock_hz),
    .len      (window_dec)
  );

  // Input register: stall only while a held beat cannot advance.
  assign in_stall  = item_vld && !take;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_accept) begin
      item_vld <= 1'b1;
    end else if (take) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_q.op          <= op;
      item_q.wdata       <= wdata;
      item_q.ccp_open    <= ccp_open;
      item_q.timeout_len <= timeout_dec;
      item_q.window_len  <= window_dec;
    end
  end

  wwdt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_vld     (item_vld),
    .item         (item_q),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rdata        (rdata),
    .device_reset (device_reset)
  );

  // An empty input register never pushes back.
  `WWDT_ASSERT_NOW(a_empty_no_stall, !item_vld, !in_stall)
  // A held beat with a free result slot always yields a result next cycle.
  `WWDT_ASSERT_NEXT(a_beat_advances, item_vld && !out_valid, out_valid)
  // A nonzero rdata never comes with a fire, and only ever shows the lock bit.
  `WWDT_ASSERT_NOW(a_rdata_lock_only, out_valid && rdata != '0,
                   !device_reset && rdata == wwdt_pkg::LOCK_MASK)

endmodule

FILE: rtl/wwdt_len_dec.sv
module wwdt_len_dec #(
  parameter int MAX_CODE = wwdt_pkg::MAX_CODE_DEF
) (
  input  logic [wwdt_pkg::CODE_W-1:0] code,
  input  logic [wwdt_pkg::CLK_W-1:0]  clock_hz,
  output logic [wwdt_pkg::LEN_W-1:0]  len
);

  // (8 << (code-1)) * clock / 1024 == (clock << (code+2)) >> 10
  localparam int SHIFT_MAX = (1 << wwdt_pkg::CODE_W) + 1;
  localparam int WIDE_W    = wwdt_pkg::CLK_W + SHIFT_MAX;
  localparam int CYC_W     = WIDE_W - 10;

  logic [wwdt_pkg::CODE_W:0] shamt;
  logic [WIDE_W-1:0]         wide;
  logic [CYC_W-1:0]          cycles;
  logic                      code_ok;

  assign shamt   = {1'b0, code} + (wwdt_pkg::CODE_W + 1)'(2);
  assign wide    = {{SHIFT_MAX{1'b0}}, clock_hz} << shamt;
  assign cycles  = wide[WIDE_W-1:10];
  assign code_ok = (code != '0) && (32'(code) <= 32'(MAX_CODE));

  always_comb begin
    if (!code_ok) begin
      len = '0;
    end else if (cycles == '0) begin
      len = wwdt_pkg::LEN_W'(1);
    end else if (|cycles[CYC_W-1:wwdt_pkg::LEN_W]) begin
      len = '1;
    end else begin
      len = cycles[wwdt_pkg::LEN_W-1:0];
    end
  end

endmodule

FILE: rtl/wwdt_core.sv
module wwdt_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_vld,
  input  wwdt_pkg::item_t             item,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wwdt_pkg::BYTE_W-1:0] rdata,
  output logic                        device_reset
);

  logic [wwdt_pkg::BYTE_W-1:0] control_byte, control_byte_next;
  logic                        lock_bit, lock_bit_next;
  logic [wwdt_pkg::LEN_W-1:0]  timeout_len, timeout_len_next;
  logic [wwdt_pkg::LEN_W-1:0]  window_len, window_len_next;
  logic [wwdt_pkg::LEN_W-1:0]  elapsed_count, elapsed_count_next;
  logic [wwdt_pkg::BYTE_W-1:0] rdata_next;
  logic                        fire;

  assign take = item_vld && (!out_valid || !out_stall);

  always_comb begin
    control_byte_next  = control_byte;
    lock_bit_next      = lock_bit;
    timeout_len_next   = timeout_len;
    window_len_next    = window_len;
    elapsed_count_next = elapsed_count;
    rdata_next         = '0;
    fire               = 1'b0;
    case (item.op)
      wwdt_pkg::OP_TICK: begin
        if (timeout_len != '0) begin
          if (elapsed_count != '1) begin
            elapsed_count_next = elapsed_count + wwdt_pkg::LEN_W'(1);
          end
          fire = (elapsed_count_next >= timeout_len);
        end
      end
      wwdt_pkg::OP_WDR: begin
        if (timeout_len != '0) begin
          if (window_len != '0 && elapsed_count < window_len) begin
            fire = 1'b1;
          end else begin
            elapsed_count_next = '0;
          end
        end
      end
      wwdt_pkg::OP_WR_CTRL: begin
        if (!lock_bit && item.ccp_open) begin
          control_byte_next  = item.wdata;
          timeout_len_next   = item.timeout_len;
          window_len_next    = item.window_len;
          elapsed_count_next = '0;
        end
      end
      wwdt_pkg::OP_WR_STAT: begin
        if ((item.wdata & wwdt_pkg::LOCK_MASK) != '0) begin
          lock_bit_next = 1'b1;
        end
      end
      wwdt_pkg::OP_RD_STAT: begin
        rdata_next = lock_bit ? wwdt_pkg::LOCK_MASK : '0;
      end
      default: begin
      end
    endcase
    if (fire) begin
      control_byte_next  = '0;
      lock_bit_next      = 1'b0;
      timeout_len_next   = '0;
      window_len_next    = '0;
      elapsed_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte  <= '0;
      lock_bit      <= 1'b0;
      timeout_len   <= '0;
      window_len    <= '0;
      elapsed_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        control_byte  <= control_byte_next;
        lock_bit      <= lock_bit_next;
        timeout_len   <= timeout_len_next;
        window_len    <= window_len_next;
        elapsed_count <= elapsed_count_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load with each processed beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (take) begin
      rdata        <= rdata_next;
      device_reset <= fire;
    end
  end

endmodule

FILE: sim/windowed_watchdog_timer_tb.sv
module windowed_watchdog_timer_tb;
  import wwdt_pkg::*;

  // Ops 5 to 7 have no meaning; the block must pass them through as no-ops.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_W'(5);
  localparam logic [OP_W-1:0] OP_UNUSED_HI = OP_W'(7);

  // Two register stages between acceptance and result; pad a little.
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int PHASE_BEATS  = 110;
  localparam int NUM_PHASES   = 8;
  localparam int NUM_DIRECTED = 32;
  localparam int MAX_PRINTS   = 60;

  typedef struct packed {
    logic [BYTE_W-1:0] rdata;
    logic              dev_reset;
  } wd_result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] wdata;
    logic              ccp;
    wd_result_t        res;
  } beat_t;

  // A directed row is a beat checked by the predictor, a beat with its
  // result typed in, or a clock_hz write.
  typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    beat_t       beat;
    logic [31:0] cfg_val;
  } dir_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op        = OP_TICK;
  logic [BYTE_W-1:0]   wdata     = '0;
  logic                ccp_open  = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   rdata;
  logic                device_reset;

  // Predictor state: a private copy of the watchdog and its clock setting.
  logic [CLK_W-1:0]    sim_clock_hz = CLOCK_HZ_RST;
  logic [BYTE_W-1:0]   sim_ctrl     = '0;
  logic                sim_lock     = 1'b0;
  logic [LEN_W-1:0]    sim_timeout  = '0;
  logic [LEN_W-1:0]    sim_window   = '0;
  logic [LEN_W-1:0]    sim_elapsed  = '0;

  wd_result_t          owed_results[$];
  wd_result_t          cur_expect   = '0;
  logic                cur_typed    = 1'b0;
  int                  errors       = 0;
  int                  cycle_count  = 0;
  int                  burst_left   = 0;
  int                  wdr_pct      = 10;
  stall_mode_t         stall_mode   = STALL_NONE;
  int                  stall_span   = 0;
  int                  stall_period = 2;
  int                  stall_phase  = 0;

  logic [31:0] phase_hz [NUM_PHASES] = '{
    32'd1, 32'd0, 32'd128, 32'd100000000, 32'hF800_0080, 32'd1000,
    32'd16000000, 32'h07FF_FFFF
  };

  // Directed walk: reset state, idle ops, ignored writes, the early-WDR and
  // timeout resets, the zero clock, codes past the top, and the sticky lock.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_TYPED, '{OP_RD_STAT,   8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_TICK,      8'hFF, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WDR,       8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_UNUSED_LO, 8'hFF, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_UNUSED_HI, 8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WR_CTRL,   8'h11, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WR_CTRL,   8'h11, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WDR,       8'h00, 1'b1, '{8'h00, 1'b1}}, 32'd0},
    '{ROW_CFG,   '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WR_CTRL,   8'h01, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b1}}, 32'd0},
    '{ROW_CFG,   '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd1},
    '{ROW_PRED,  '{OP_WR_CTRL,   8'h9B, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_TICK,      8'hAA, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_WDR,       8'h55, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_WR_CTRL,   8'hFC, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_WR_CTRL,   8'h08, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WR_STAT,   8'h7F, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_RD_STAT,   8'hFF, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WR_STAT,   8'h80, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_RD_STAT,   8'h00, 1'b0, '{8'h80, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WR_CTRL,   8'h00, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b1}}, 32'd0},
    '{ROW_TYPED, '{OP_RD_STAT,   8'h00, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_CFG,   '{OP_TICK,      8'h00, 1'b0, '{8'h00, 1'b0}}, 32'h07FF_FFFF},
    '{ROW_PRED,  '{OP_WR_CTRL,   8'hBB, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_TYPED, '{OP_WDR,       8'h00, 1'b0, '{8'h00, 1'b1}}, 32'd0},
    '{ROW_PRED,  '{OP_WR_CTRL,   8'hFF, 1'b0, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_WR_CTRL,   8'hF1, 1'b1, '{8'h00, 1'b0}}, 32'd0},
    '{ROW_PRED,  '{OP_WDR,       8'h00, 1'b1, '{8'h00, 1'b0}}, 32'd0}
  };

  windowed_watchdog_timer i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .wdata        (wdata),
    .ccp_open     (ccp_open),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rdata        (rdata),
    .device_reset (device_reset)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Convert a period code to a cycle count at the current clock setting.
  function automatic logic [LEN_W-1:0] code_to_len(input logic [CODE_W-1:0] code,
                                                   input logic [CLK_W-1:0] hz);
    logic [63:0] cycles;
    if (code < 1 || code > MAX_CODE_DEF) return '0;
    cycles = ((64'd8 << (code - 1)) * 64'(hz)) / 64'd1024;
    if (cycles == 0) return LEN_W'(1);
    if (cycles > 64'hFFFF_FFFF) return '1;
    return cycles[LEN_W-1:0];
  endfunction

  // Advance the predictor by one beat and return the result it owes.
  task automatic predict_watchdog(input logic [OP_W-1:0] b_op, input logic [BYTE_W-1:0] b_wdata,
                                  input logic b_ccp, output wd_result_t res);
    logic fire;
    fire = 1'b0;
    res = '0;
    case (b_op)
      OP_TICK: begin
        if (sim_timeout != 0) begin
          if (sim_elapsed != '1) sim_elapsed = sim_elapsed + 1;
          if (sim_elapsed >= sim_timeout) fire = 1'b1;
        end
      end
      OP_WDR: begin
        if (sim_timeout != 0) begin
          if (sim_window != 0 && sim_elapsed < sim_window) fire = 1'b1;
          else sim_elapsed = '0;
        end
      end
      OP_WR_CTRL: begin
        if (!sim_lock && b_ccp) begin
          sim_ctrl    = b_wdata;
          sim_timeout = code_to_len(b_wdata[3:0], sim_clock_hz);
          sim_window  = code_to_len(b_wdata[7:4], sim_clock_hz);
          sim_elapsed = '0;
        end
      end
      OP_WR_STAT: begin
        if ((b_wdata & LOCK_MASK) != 0) sim_lock = 1'b1;
      end
      OP_RD_STAT: begin
        res.rdata = sim_lock ? LOCK_MASK : '0;
      end
      default: ;
    endcase
    // A watchdog reset wipes everything but the clock setting.
    if (fire) begin
      sim_ctrl    = '0;
      sim_lock    = 1'b0;
      sim_timeout = '0;
      sim_window  = '0;
      sim_elapsed = '0;
    end
    res.dev_reset = fire;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTS)
      $display("%0t: %s got 'h%0h want 'h%0h", $time, what, got, want);
    errors++;
  endtask

  // Present one beat and hold it until taken. Entered and left just after a
  // falling edge; random gaps between bursts drop valid.
  task automatic send_beat(input beat_t b, input logic typed);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 12 : 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    op         <= b.op;
    wdata      <= b.wdata;
    ccp_open   <= b.ccp;
    cur_typed  = typed;
    cur_expect = b.res;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Drain the block, then write clock_hz with an APB setup phase and an access phase.
  task automatic write_clock_hz(input logic [31:0] value);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CLOCK_HZ;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sim_clock_hz = value[CLK_W-1:0];
  endtask

  // Build the next random beat from the predictor's current state. Mostly
  // arm the watchdog and then tick and restart it, so the window and the
  // timeout both get reached; sprinkle in noise and status traffic.
  task automatic make_random_beat(output beat_t b);
    logic [CODE_W-1:0] tcode;
    logic [CODE_W-1:0] wcode;
    int                pick;
    b       = '0;
    b.wdata = BYTE_W'($urandom);
    b.ccp   = 1'($urandom);
    if (sim_timeout == 0 && !sim_lock && $urandom_range(0, 9) < 8) begin
      // Skew toward short periods so timeouts actually land.
      if ($urandom_range(0, 9) < 8) tcode = CODE_W'($urandom_range(1, $urandom_range(1, 11)));
      else tcode = CODE_W'($urandom);
      if ($urandom_range(0, 2) == 0) wcode = '0;
      else wcode = CODE_W'($urandom_range(0, tcode));
      b.op    = OP_WR_CTRL;
      b.wdata = {wcode, tcode};
      b.ccp   = ($urandom_range(0, 15) != 0);
      wdr_pct = $urandom_range(0, 25);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < wdr_pct) begin
        // Hold off restarts while locked so the timeout can clear the lock.
        b.op = (sim_lock && pick > 1) ? OP_TICK : OP_WDR;
      end else if (pick < wdr_pct + 6) begin
        b.op = OP_WR_CTRL;
      end else if (pick < wdr_pct + 10) begin
        b.op = OP_WR_STAT;
        // Set the lock only when a short timeout will release it again.
        b.wdata[7] = (sim_timeout != 0 && sim_timeout <= 64 && $urandom_range(0, 2) == 0);
      end else if (pick < wdr_pct + 14) begin
        b.op = OP_RD_STAT;
      end else if (pick < wdr_pct + 16) begin
        b.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
        b.op = OP_TICK;
      end
    end
  endtask

  // Score results against the oldest owed result, then predict any beat
  // taken at this edge. Outputs are read before this edge's updates land.
  always @(posedge clk) begin
    wd_result_t got;
    wd_result_t want;
    wd_result_t predicted;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{rdata, device_reset};
        if (owed_results.size() == 0) begin
          flag_mismatch("unexpected result, rdata", got.rdata, 0);
        end else begin
          want = owed_results.pop_front();
          if (got.rdata != want.rdata) flag_mismatch("rdata", got.rdata, want.rdata);
          if (got.dev_reset != want.dev_reset)
            flag_mismatch("device_reset", got.dev_reset, want.dev_reset);
        end
      end
      if (in_valid && !in_stall) begin
        predict_watchdog(op, wdata, ccp_open, predicted);
        owed_results.push_back(cur_typed ? cur_expect : predicted);
      end
    end
  end

  // Receiver back-pressure: switch among pattern styles at random intervals.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode   = stall_mode_t'($urandom_range(0, 3));
      stall_span   = $urandom_range(16, 96);
      stall_period = $urandom_range(2, 7);
      stall_phase  = 0;
    end
    stall_span--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
      STALL_PERIODIC: out_stall <= ((stall_phase % stall_period) == 0);
      default:        out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("windowed_watchdog_timer: mismatch");
      $finish;
    end
  end

  initial begin
    beat_t b;
    int    sent;
    phase_hz[5] = $urandom_range(2, 3000);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table; config rows drain the block first.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_CFG) write_clock_hz(directed_rows[i].cfg_val);
      else send_beat(directed_rows[i].beat, directed_rows[i].kind == ROW_TYPED);
    end

    // Random phases, one clock setting each; unused ops do not count.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_clock_hz(phase_hz[p]);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        make_random_beat(b);
        send_beat(b, 1'b0);
        if (b.op <= OP_RD_STAT) sent++;
      end
    end

    // Drop valid, wait out every owed result, then let the pipe settle.
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("windowed_watchdog_timer: match");
    end else begin
      $display("windowed_watchdog_timer: mismatch");
    end
    $finish;
  end

endmodule
